[src/mld_pkg.sv]
`default_nettype none
package mld_pkg;

   localparam int MAX_LINES_DEF = 1024;
   localparam int MAX_EDITS_DEF = 256;
   localparam int SNAP_WORDS_DEF = 65536;
   localparam int TOKEN_BITS_DEF = 32;

   localparam int OPC_W = 3;
   localparam int TOK_W = 32;
   localparam int STAT_W = 2;
   localparam int DIST_W = 9;
   localparam int LINE_W = 10;
   localparam int LIMIT_W = 9;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

   localparam logic [OPC_W-1:0] OP_LOAD_A = 3'd0;
   localparam logic [OPC_W-1:0] OP_LOAD_B = 3'd1;
   localparam logic [OPC_W-1:0] OP_RUN    = 3'd2;
   localparam logic [OPC_W-1:0] OP_FETCH  = 3'd3;
   localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] ST_IDENT  = 2'd0;
   localparam logic [STAT_W-1:0] ST_DIFFER = 2'd1;
   localparam logic [STAT_W-1:0] ST_LARGE  = 2'd2;

   localparam logic KIND_RUN  = 1'b0;
   localparam logic KIND_EDIT = 1'b1;

endpackage
`default_nettype wire

[src/myers_line_diff_engine.sv]
// load and clear words are accepted back to back while the engine is idle
// run: prefix scan, suffix scan, then per diagonal a snapshot read, the snake compares and a snapshot write;
//   all reads go through the single read port of the line memories and the snapshot memory
// fetch: per edit word, square of the step minus one, then two snapshot reads
// synchronous reset clears control, counts and trace state; memories are not cleared
`default_nettype none
module myers_line_diff_engine #(
   parameter int MAX_LINES_PER_SIDE = mld_pkg::MAX_LINES_DEF,
   parameter int MAX_EDITS = mld_pkg::MAX_EDITS_DEF,
   parameter int SNAP_WORDS = mld_pkg::SNAP_WORDS_DEF,
   parameter int TOKEN_BITS = mld_pkg::TOKEN_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [mld_pkg::OPC_W-1:0]    req_opcode,
   input  wire logic [mld_pkg::TOK_W-1:0]    req_line_token,
   input  wire logic                         req_line_noeol,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_kind,
   output logic      [mld_pkg::STAT_W-1:0]   rsp_status,
   output logic      [mld_pkg::DIST_W-1:0]   rsp_edit_distance,
   output logic                              rsp_edit_is_insert,
   output logic      [mld_pkg::LINE_W-1:0]   rsp_edit_line,
   output logic                              rsp_last,
   input  wire logic                         csr_wr_en,
   input  wire logic [mld_pkg::LIMIT_W-1:0]  csr_wr_data
);

   localparam int AW = $clog2(MAX_LINES_PER_SIDE);
   localparam int CNT_W = $clog2(MAX_LINES_PER_SIDE + 1);
   localparam int DW = $clog2(MAX_EDITS + 1);
   localparam int XW = $clog2(MAX_LINES_PER_SIDE + MAX_EDITS + 2);
   localparam int CW = XW + 2;
   localparam int SAW = $clog2(SNAP_WORDS);
   localparam int UW = SAW + 1;
   localparam int LW = TOKEN_BITS + 1;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_PRE_RD  = 4'd1;
   localparam logic [3:0] S_PRE_CMP = 4'd2;
   localparam logic [3:0] S_SUF_RD  = 4'd3;
   localparam logic [3:0] S_SUF_CMP = 4'd4;
   localparam logic [3:0] S_SETUP   = 4'd5;
   localparam logic [3:0] S_K_RD    = 4'd6;
   localparam logic [3:0] S_K_X     = 4'd7;
   localparam logic [3:0] S_SN_RD   = 4'd8;
   localparam logic [3:0] S_SN_CMP  = 4'd9;
   localparam logic [3:0] S_K_WR    = 4'd10;
   localparam logic [3:0] S_F_MUL   = 4'd11;
   localparam logic [3:0] S_F_R1    = 4'd12;
   localparam logic [3:0] S_F_R2    = 4'd13;
   localparam logic [3:0] S_F_DO    = 4'd14;
   localparam logic [3:0] S_EMIT    = 4'd15;

   // control state
   logic [3:0] state_ff, state_in;
   logic [CNT_W-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic ovf_ff, ovf_in;
   logic [CNT_W-1:0] pfx_ff, pfx_in;
   logic [UW-1:0] used_ff, used_in;
   logic [DW-1:0] found_ff, found_in;
   logic signed [CW-1:0] tx_ff, tx_in, ty_ff, ty_in;
   logic [DW-1:0] tstep_ff, tstep_in;
   logic [mld_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [CNT_W-1:0] sfx_ff, sfx_in, n_ff, n_in, m_ff, m_in;
   logic [DW-1:0] d_ff, d_in, dmax_ff, dmax_in;
   logic signed [CW-1:0] k_ff, k_in, x_ff, x_in, y_ff, y_in, km1_ff, km1_in;
   logic [UW-1:0] prevbase_ff, prevbase_in;
   logic [2*DW-1:0] fbase_ff, fbase_in;
   logic res_kind_ff, res_kind_in, res_ins_ff, res_ins_in, res_last_ff, res_last_in;
   logic [mld_pkg::STAT_W-1:0] res_status_ff, res_status_in;
   logic [mld_pkg::DIST_W-1:0] res_dist_ff, res_dist_in;
   logic [mld_pkg::LINE_W-1:0] res_line_ff, res_line_in;
   logic rsp_kind_ff, rsp_kind_in, rsp_ins_ff, rsp_ins_in, rsp_last_ff, rsp_last_in;
   logic [mld_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [mld_pkg::DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic [mld_pkg::LINE_W-1:0] rsp_line_ff, rsp_line_in;

   // memory ports
   logic la_we, lb_we;
   logic [AW-1:0] l_waddr, la_raddr, lb_raddr;
   logic [LW-1:0] l_wdata, la_rdata, lb_rdata;
   logic s_we;
   logic [SAW-1:0] s_waddr, s_raddr;
   logic [XW-1:0] s_wdata, s_rdata;

   // helpers
   logic accept, out_free, lines_eq, store_ok, down;
   logic signed [CW-1:0] ds, sds, ns, ms, snap_s, vkp1, xc, kq, pk, px, py;
   logic [CW-1:0] kd_u, kq_u;
   logic [DW-1:0] sd, lim;
   logic [CNT_W-1:0] n_c, m_c;
   logic [CNT_W:0] nm;

   mld_ram #(.WIDTH(LW), .DEPTH(MAX_LINES_PER_SIDE)) u_first (
      .clock(clock), .wr_en(la_we), .wr_addr(l_waddr), .wr_data(l_wdata),
      .rd_addr(la_raddr), .rd_data(la_rdata)
   );

   mld_ram #(.WIDTH(LW), .DEPTH(MAX_LINES_PER_SIDE)) u_second (
      .clock(clock), .wr_en(lb_we), .wr_addr(l_waddr), .wr_data(l_wdata),
      .rd_addr(lb_raddr), .rd_data(lb_rdata)
   );

   mld_ram #(.WIDTH(XW), .DEPTH(SNAP_WORDS)) u_snap (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_addr(s_raddr), .rd_data(s_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign lines_eq = (la_rdata == lb_rdata);

   assign ds = $signed(CW'(d_ff));
   assign ns = $signed(CW'(n_ff));
   assign ms = $signed(CW'(m_ff));
   assign snap_s = $signed(CW'(s_rdata));
   assign kd_u = CW'(k_ff + ds);
   assign sd = tstep_ff - DW'(1);
   assign sds = $signed(CW'(sd));
   assign store_ok = (32'(used_ff) + 32'({d_ff, 1'b1})) <= 32'(SNAP_WORDS);
   assign lim = (32'(limit_ff) > MAX_EDITS) ? DW'(MAX_EDITS) : DW'(limit_ff);
   assign n_c = cnt_a_ff - pfx_ff - sfx_ff;
   assign m_c = cnt_b_ff - pfx_ff - sfx_ff;
   assign nm = (CNT_W+1)'(n_c) + (CNT_W+1)'(m_c);

   always_comb begin
      state_in = state_ff;
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      ovf_in = ovf_ff;
      pfx_in = pfx_ff;
      used_in = used_ff;
      found_in = found_ff;
      tx_in = tx_ff;
      ty_in = ty_ff;
      tstep_in = tstep_ff;
      limit_in = csr_wr_en ? csr_wr_data : limit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sfx_in = sfx_ff;
      n_in = n_ff;
      m_in = m_ff;
      d_in = d_ff;
      dmax_in = dmax_ff;
      k_in = k_ff;
      x_in = x_ff;
      y_in = y_ff;
      km1_in = km1_ff;
      prevbase_in = prevbase_ff;
      fbase_in = fbase_ff;
      res_kind_in = res_kind_ff;
      res_status_in = res_status_ff;
      res_dist_in = res_dist_ff;
      res_ins_in = res_ins_ff;
      res_line_in = res_line_ff;
      res_last_in = res_last_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_dist_in = rsp_dist_ff;
      rsp_ins_in = rsp_ins_ff;
      rsp_line_in = rsp_line_ff;
      rsp_last_in = rsp_last_ff;
      la_we = 1'b0;
      lb_we = 1'b0;
      l_waddr = cnt_a_ff[AW-1:0];
      l_wdata = {req_line_noeol, TOKEN_BITS'(req_line_token)};
      la_raddr = pfx_ff[AW-1:0];
      lb_raddr = pfx_ff[AW-1:0];
      s_we = 1'b0;
      s_waddr = SAW'(used_ff + UW'(kd_u));
      s_wdata = XW'(x_ff);
      s_raddr = SAW'(prevbase_ff + UW'(kd_u));
      vkp1 = '0;
      xc = '0;
      kq = '0;
      kq_u = '0;
      pk = '0;
      px = '0;
      py = '0;
      down = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  mld_pkg::OP_LOAD_A: begin
                     tstep_in = '0;
                     if (cnt_a_ff < CNT_W'(MAX_LINES_PER_SIDE)) begin
                        la_we = 1'b1;
                        cnt_a_in = cnt_a_ff + CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  mld_pkg::OP_LOAD_B: begin
                     tstep_in = '0;
                     l_waddr = cnt_b_ff[AW-1:0];
                     if (cnt_b_ff < CNT_W'(MAX_LINES_PER_SIDE)) begin
                        lb_we = 1'b1;
                        cnt_b_in = cnt_b_ff + CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  mld_pkg::OP_RUN: begin
                     tstep_in = '0;
                     found_in = '0;
                     used_in = '0;
                     pfx_in = '0;
                     sfx_in = '0;
                     prevbase_in = '0;
                     if (ovf_ff) begin
                        res_kind_in = mld_pkg::KIND_RUN;
                        res_status_in = mld_pkg::ST_LARGE;
                        res_dist_in = '0;
                        res_ins_in = 1'b0;
                        res_line_in = '0;
                        res_last_in = 1'b0;
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_PRE_RD;
                     end
                  end
                  mld_pkg::OP_FETCH: begin
                     if (tstep_ff != '0) begin
                        state_in = S_F_MUL;
                     end
                  end
                  mld_pkg::OP_CLEAR: begin
                     cnt_a_in = '0;
                     cnt_b_in = '0;
                     ovf_in = 1'b0;
                     pfx_in = '0;
                     used_in = '0;
                     found_in = '0;
                     tx_in = '0;
                     ty_in = '0;
                     tstep_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PRE_RD: begin
            if (pfx_ff < cnt_a_ff && pfx_ff < cnt_b_ff) begin
               state_in = S_PRE_CMP;
            end else begin
               state_in = S_SUF_RD;
            end
         end
         S_PRE_CMP: begin
            if (lines_eq) begin
               pfx_in = pfx_ff + CNT_W'(1);
               state_in = S_PRE_RD;
            end else begin
               state_in = S_SUF_RD;
            end
         end
         S_SUF_RD: begin
            la_raddr = AW'(cnt_a_ff - CNT_W'(1) - sfx_ff);
            lb_raddr = AW'(cnt_b_ff - CNT_W'(1) - sfx_ff);
            if (sfx_ff < cnt_a_ff - pfx_ff && sfx_ff < cnt_b_ff - pfx_ff) begin
               state_in = S_SUF_CMP;
            end else begin
               state_in = S_SETUP;
            end
         end
         S_SUF_CMP: begin
            if (lines_eq) begin
               sfx_in = sfx_ff + CNT_W'(1);
               state_in = S_SUF_RD;
            end else begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            n_in = n_c;
            m_in = m_c;
            if (n_c == '0 && m_c == '0) begin
               res_kind_in = mld_pkg::KIND_RUN;
               res_status_in = mld_pkg::ST_IDENT;
               res_dist_in = '0;
               res_ins_in = 1'b0;
               res_line_in = '0;
               res_last_in = 1'b0;
               state_in = S_EMIT;
            end else begin
               dmax_in = (32'(nm) < 32'(lim)) ? DW'(nm) : lim;
               d_in = '0;
               k_in = '0;
               state_in = S_K_RD;
            end
         end
         S_K_RD: begin
            state_in = S_K_X;
         end
         S_K_X: begin
            vkp1 = (d_ff == '0) ? '0 : snap_s;
            if (k_ff == -ds || (k_ff != ds && km1_ff < vkp1)) begin
               xc = vkp1;
            end else begin
               xc = km1_ff + CW'(1);
            end
            x_in = xc;
            y_in = xc - k_ff;
            km1_in = vkp1;
            state_in = S_SN_RD;
         end
         S_SN_RD: begin
            la_raddr = AW'(CW'(pfx_ff) + x_ff);
            lb_raddr = AW'(CW'(pfx_ff) + y_ff);
            if (x_ff >= 0 && y_ff >= 0 && x_ff < ns && y_ff < ms) begin
               state_in = S_SN_CMP;
            end else begin
               state_in = S_K_WR;
            end
         end
         S_SN_CMP: begin
            if (lines_eq) begin
               x_in = x_ff + CW'(1);
               y_in = y_ff + CW'(1);
               state_in = S_SN_RD;
            end else begin
               state_in = S_K_WR;
            end
         end
         S_K_WR: begin
            s_we = store_ok;
            res_kind_in = mld_pkg::KIND_RUN;
            res_dist_in = '0;
            res_ins_in = 1'b0;
            res_line_in = '0;
            res_last_in = 1'b0;
            if (x_ff >= ns && y_ff >= ms) begin
               res_status_in = mld_pkg::ST_DIFFER;
               res_dist_in = mld_pkg::DIST_W'(d_ff);
               found_in = d_ff;
               tstep_in = d_ff;
               tx_in = ns;
               ty_in = ms;
               state_in = S_EMIT;
            end else if (k_ff == ds) begin
               if (d_ff == dmax_ff || !store_ok) begin
                  res_status_in = mld_pkg::ST_LARGE;
                  state_in = S_EMIT;
               end else begin
                  prevbase_in = used_ff;
                  used_in = used_ff + UW'({d_ff, 1'b1});
                  d_in = d_ff + DW'(1);
                  k_in = -(ds + CW'(1));
                  state_in = S_K_RD;
               end
            end else begin
               k_in = k_ff + CW'(2);
               state_in = S_K_RD;
            end
         end
         S_F_MUL: begin
            fbase_in = (2*DW)'(sd) * (2*DW)'(sd);
            k_in = tx_ff - ty_ff;
            state_in = S_F_R1;
         end
         S_F_R1: begin
            kq = k_ff - CW'(1);
            kq_u = CW'(kq + sds);
            s_raddr = SAW'(fbase_ff) + SAW'(kq_u);
            state_in = S_F_R2;
         end
         S_F_R2: begin
            kq = k_ff - CW'(1);
            km1_in = (kq >= -sds && kq <= sds) ? snap_s : '0;
            kq = k_ff + CW'(1);
            kq_u = CW'(kq + sds);
            s_raddr = SAW'(fbase_ff) + SAW'(kq_u);
            state_in = S_F_DO;
         end
         S_F_DO: begin
            kq = k_ff + CW'(1);
            vkp1 = (kq >= -sds && kq <= sds) ? snap_s : '0;
            down = (k_ff == -$signed(CW'(tstep_ff))) ||
                   (k_ff != $signed(CW'(tstep_ff)) && km1_ff < vkp1);
            pk = down ? k_ff + CW'(1) : k_ff - CW'(1);
            px = down ? vkp1 : km1_ff;
            py = px - pk;
            res_kind_in = mld_pkg::KIND_EDIT;
            res_status_in = mld_pkg::ST_DIFFER;
            res_dist_in = mld_pkg::DIST_W'(found_ff);
            res_ins_in = down;
            res_line_in = mld_pkg::LINE_W'(CW'(pfx_ff) + (down ? py : px));
            res_last_in = (tstep_ff == DW'(1));
            tx_in = px;
            ty_in = py;
            tstep_in = sd;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = res_kind_ff;
               rsp_status_in = res_status_ff;
               rsp_dist_in = res_dist_ff;
               rsp_ins_in = res_ins_ff;
               rsp_line_in = res_line_ff;
               rsp_last_in = res_last_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
         ovf_ff <= 1'b0;
         pfx_ff <= '0;
         used_ff <= '0;
         found_ff <= '0;
         tx_ff <= '0;
         ty_ff <= '0;
         tstep_ff <= '0;
         limit_ff <= mld_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
         ovf_ff <= ovf_in;
         pfx_ff <= pfx_in;
         used_ff <= used_in;
         found_ff <= found_in;
         tx_ff <= tx_in;
         ty_ff <= ty_in;
         tstep_ff <= tstep_in;
         limit_ff <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sfx_ff <= sfx_in;
      n_ff <= n_in;
      m_ff <= m_in;
      d_ff <= d_in;
      dmax_ff <= dmax_in;
      k_ff <= k_in;
      x_ff <= x_in;
      y_ff <= y_in;
      km1_ff <= km1_in;
      prevbase_ff <= prevbase_in;
      fbase_ff <= fbase_in;
      res_kind_ff <= res_kind_in;
      res_status_ff <= res_status_in;
      res_dist_ff <= res_dist_in;
      res_ins_ff <= res_ins_in;
      res_line_ff <= res_line_in;
      res_last_ff <= res_last_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_ins_ff <= rsp_ins_in;
      rsp_line_ff <= rsp_line_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_edit_distance = rsp_dist_ff;
   assign rsp_edit_is_insert = rsp_ins_ff;
   assign rsp_edit_line = rsp_line_ff;
   assign rsp_last = rsp_last_ff;

   a_trace_within_found: assert property (@(posedge clock) disable iff (reset)
      tstep_ff <= found_ff)
      else $error("trace step beyond found distance");

   a_load_counts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == mld_pkg::OP_LOAD_A &&
       cnt_a_ff < CNT_W'(MAX_LINES_PER_SIDE))
      |=> cnt_a_ff == $past(cnt_a_ff) + CNT_W'(1))
      else $error("first line count did not advance");

   a_prefix_bound: assert property (@(posedge clock) disable iff (reset)
      pfx_ff <= cnt_a_ff && pfx_ff <= cnt_b_ff)
      else $error("prefix longer than a sequence");

   a_emit_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && !out_free) |=> state_ff == S_EMIT && $stable(res_line_ff))
      else $error("pending word lost while output busy");

endmodule
`default_nettype wire

[src/mld_ram.sv]
`default_nettype none
module mld_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire
